>>> design/mkx_pkg.sv
// Shared types, constants and helpers for the keystream XOR cipher.
package mkx_pkg;

  localparam logic [63:0] GOLD_MUL   = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] DOMAIN_MUL = 64'hd6e8_feb8_6659_fd93;
  localparam logic [63:0] FIN_MUL1   = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] FIN_MUL2   = 64'h94d0_49bb_1331_11eb;

  localparam int unsigned FIN_SH1 = 30;
  localparam int unsigned FIN_SH2 = 27;
  localparam int unsigned FIN_SH3 = 31;

  // partial product order of a 64x64 mod 2^64 multiply
  localparam logic [1:0] PART_LL  = 2'd0;
  localparam logic [1:0] PART_LH  = 2'd1;
  localparam logic [1:0] PART_HL  = 2'd2;
  localparam logic [1:0] PART_END = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_FOLD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_GOLD,
    OP_DOM,
    OP_FIN1,
    OP_FIN2
  } op_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] obj_id;
    logic [31:0] key_domain;
    logic [31:0] pos;
  } item_t;

  typedef struct packed {
    logic        en;
    logic        shift;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        vld;
    logic        shift;
    logic [63:0] prod;
  } mul_rsp_t;

  function automatic logic [63:0] op_const(op_e op);
    logic [63:0] k;
    case (op)
      OP_GOLD: k = GOLD_MUL;
      OP_DOM:  k = DOMAIN_MUL;
      OP_FIN1: k = FIN_MUL1;
      OP_FIN2: k = FIN_MUL2;
      default: k = GOLD_MUL;
    endcase
    return k;
  endfunction

endpackage

>>> design/mkx_mul.sv
// Registered 32x32 multiplier shared by all partial products.
module mkx_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mkx_pkg::mul_req_t req_i,
  output mkx_pkg::mul_rsp_t rsp_o
);

  logic        vld_q;
  logic        shift_q;
  logic [63:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      shift_q <= req_i.shift;
      prod_q  <= 64'(req_i.a) * 64'(req_i.b);
    end
  end

  assign rsp_o.vld   = vld_q;
  assign rsp_o.shift = shift_q;
  assign rsp_o.prod  = prod_q;

endmodule

>>> design/mkx_core.sv
// Sequencer and datapath: keystream word build, splitmix64 finalizer, byte XOR.
module mkx_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [63:0]    seed_i,
  input  logic           start_i,
  input  mkx_pkg::item_t item_i,
  output logic           ready_o,
  output logic           done_o,
  output logic [7:0]     result_o,
  input  logic           take_i
);

  mkx_pkg::state_e   st_q, st_d;
  mkx_pkg::op_e      op_q, op_d;
  logic [1:0]        part_q, part_d;
  logic [63:0]       x_q, x_d;
  logic [63:0]       acc_q, acc_d;
  logic [63:0]       w_q, w_d;
  mkx_pkg::item_t    item_q, item_d;
  mkx_pkg::mul_req_t mul_req;
  mkx_pkg::mul_rsp_t mul_rsp;
  logic [63:0]       k;
  logic [63:0]       addend;
  logic [63:0]       fin;

  mkx_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign k      = mkx_pkg::op_const(op_q);
  assign addend = mul_rsp.shift ? {mul_rsp.prod[31:0], 32'b0} : mul_rsp.prod;
  assign fin    = w_q ^ (w_q >> mkx_pkg::FIN_SH3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= mkx_pkg::ST_IDLE;
      op_q   <= mkx_pkg::OP_GOLD;
      part_q <= mkx_pkg::PART_LL;
    end else begin
      st_q   <= st_d;
      op_q   <= op_d;
      part_q <= part_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    acc_q  <= acc_d;
    w_q    <= w_d;
    item_q <= item_d;
  end

  always_comb begin
    st_d     = st_q;
    op_d     = op_q;
    part_d   = part_q;
    x_d      = x_q;
    acc_d    = acc_q;
    w_d      = w_q;
    item_d   = item_q;
    mul_req  = '0;
    ready_o  = 1'b0;
    done_o   = 1'b0;
    result_o = item_q.data_byte ^ 8'(fin >> {item_q.pos[2:0], 3'b000});

    if (mul_rsp.vld) begin
      acc_d = acc_q + addend;
    end

    case (st_q)
      mkx_pkg::ST_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          item_d = item_i;
          op_d   = mkx_pkg::OP_GOLD;
          st_d   = mkx_pkg::ST_LOAD;
        end
      end
      mkx_pkg::ST_LOAD: begin
        case (op_q)
          mkx_pkg::OP_GOLD: x_d = {32'b0, item_q.obj_id};
          mkx_pkg::OP_DOM:  x_d = {32'b0, item_q.key_domain};
          mkx_pkg::OP_FIN1: x_d = w_q ^ (w_q >> mkx_pkg::FIN_SH1);
          mkx_pkg::OP_FIN2: x_d = w_q ^ (w_q >> mkx_pkg::FIN_SH2);
          default:          x_d = w_q;
        endcase
        acc_d  = '0;
        part_d = mkx_pkg::PART_LL;
        st_d   = mkx_pkg::ST_MUL;
      end
      mkx_pkg::ST_MUL: begin
        case (part_q)
          mkx_pkg::PART_LL: begin
            mul_req = '{en: 1'b1, shift: 1'b0, a: x_q[31:0], b: k[31:0]};
          end
          mkx_pkg::PART_LH: begin
            mul_req = '{en: 1'b1, shift: 1'b1, a: x_q[31:0], b: k[63:32]};
          end
          mkx_pkg::PART_HL: begin
            mul_req = '{en: 1'b1, shift: 1'b1, a: x_q[63:32], b: k[31:0]};
          end
          default: begin
            mul_req = '0;
          end
        endcase
        if (part_q == mkx_pkg::PART_END) begin
          st_d = mkx_pkg::ST_FOLD;
        end else begin
          part_d = part_q + 2'd1;
        end
      end
      mkx_pkg::ST_FOLD: begin
        case (op_q)
          mkx_pkg::OP_GOLD: w_d = seed_i ^ acc_q;
          mkx_pkg::OP_DOM:  w_d = w_q ^ acc_q ^ {35'b0, item_q.pos[31:3]};
          default:          w_d = acc_q;
        endcase
        if (op_q == mkx_pkg::OP_FIN2) begin
          st_d = mkx_pkg::ST_DONE;
        end else begin
          op_d = mkx_pkg::op_e'(op_q + 2'd1);
          st_d = mkx_pkg::ST_LOAD;
        end
      end
      mkx_pkg::ST_DONE: begin
        done_o = 1'b1;
        if (take_i) begin
          st_d = mkx_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = mkx_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/mixer_keystream_xor_cipher.sv
// Top level: seed register, byte position, handshakes and output register.
// Each byte needs twelve 32x32 partial products on the single shared multiplier,
// plus load/fold steps per 64-bit product, before its result is ready.
// in_ready_o drops while a byte is in work, and while its result waits for a full output register.
// Reset clears seed, byte position, sequencer and output valid.
module mixer_keystream_xor_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] obj_id_i,
  input  logic [31:0] key_domain_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o
);

  logic [63:0]    seed_q;
  logic [31:0]    pos_q;
  logic           out_valid_q;
  logic [7:0]     out_byte_q;
  logic           in_acc;
  logic           take;
  logic           core_ready;
  logic           core_done;
  logic [7:0]     core_result;
  mkx_pkg::item_t item;

  assign in_acc     = in_valid_i && core_ready;
  assign in_ready_o = core_ready;
  assign take       = !out_valid_q || out_ready_i;

  assign item.data_byte  = data_byte_i;
  assign item.obj_id     = obj_id_i;
  assign item.key_domain = key_domain_i;
  assign item.pos        = pos_q;

  mkx_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .seed_i   (seed_q),
    .start_i  (in_acc),
    .item_i   (item),
    .ready_o  (core_ready),
    .done_o   (core_done),
    .result_o (core_result),
    .take_i   (take)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        pos_q <= last_byte_i ? 32'd0 : pos_q + 32'd1;
      end
      if (take) begin
        out_valid_q <= core_done;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && core_done) begin
      out_byte_q <= core_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("core still ready after accepting a transaction");

  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_byte_i |=> pos_q == 32'd0)
    else $error("byte position did not restart after last byte");

  a_done_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done && take |=> out_valid_o && in_ready_o)
    else $error("finished result not moved to output register");
`endif

endmodule
